/* sv/assert_macros.svh */
// Assertion macros used by the broadcast index mapper RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion label failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion label failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

/* sv/tbim_pkg.sv */
// Shared constants for the broadcast index mapper
package tbim_pkg;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int RANK_W = 3;
   localparam int LIN_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK_B = 3'd3;

   localparam logic [CSR_DATA_W-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;
   localparam logic [RANK_W-1:0] RANK_RESET = 3'd1;
endpackage

/* sv/tensor_broadcast_index_mapper.sv */
// Broadcast index mapper: pipelined divide chain plus operand index MAC
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_out_linear_index
//   rsp     | out       | rsp_valid/stall    | rsp_index_a, rsp_index_b, rsp_shape_mismatch
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One transaction per cycle sustained unless the result is stalled. Restoring divider
// chain (4 quotient bits per stage, one divide per dim), product and output registers.
// Synchronous active-high reset clears valid bits, presets the shape and rank registers.
// A stalled result freezes the whole pipeline; req_stall follows rsp_valid && rsp_stall.
// Operand strides settle through the per-dimension stride registers after a shape write.
`include "assert_macros.svh"

module tensor_broadcast_index_mapper #(
   parameter int MAX_DIMS = 4,
   parameter int DIM_BITS = 16,
   parameter int INDEX_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tbim_pkg::LIN_W-1:0]          req_out_linear_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbim_pkg::LIN_W-1:0]          rsp_index_a,
   output logic [tbim_pkg::LIN_W-1:0]          rsp_index_b,
   output logic                                rsp_shape_mismatch,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbim_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbim_pkg::CSR_DATA_W-1:0]     csr_data
);
   localparam int K = 4;
   localparam int SPD = (INDEX_BITS + K - 1) / K;
   localparam int NS = MAX_DIMS * SPD;
   localparam int RW = tbim_pkg::RANK_W;

   typedef struct packed {
      logic [INDEX_BITS-1:0] w;
      logic [DIM_BITS-1:0] r;
      logic [MAX_DIMS-1:0][DIM_BITS-1:0] c;
   } div_type;

   // config registers
   logic [tbim_pkg::CSR_DATA_W-1:0] shape_a_ff, shape_b_ff;
   logic [RW-1:0] rank_a_ff, rank_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_a_ff <= tbim_pkg::SHAPE_RESET;
         shape_b_ff <= tbim_pkg::SHAPE_RESET;
         rank_a_ff <= tbim_pkg::RANK_RESET;
         rank_b_ff <= tbim_pkg::RANK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tbim_pkg::CSR_SHAPE_A: shape_a_ff <= csr_data;
            tbim_pkg::CSR_RANK_A: rank_a_ff <= csr_data[RW-1:0];
            tbim_pkg::CSR_SHAPE_B: shape_b_ff <= csr_data;
            tbim_pkg::CSR_RANK_B: rank_b_ff <= csr_data[RW-1:0];
            default: ;
         endcase
      end
   end

   // size of operand at right-aligned position p (MAX_DIMS-1 is innermost), 1 outside rank
   function automatic logic [DIM_BITS-1:0] aligned_size(
      input logic [tbim_pkg::CSR_DATA_W-1:0] shape, input logic [RW-1:0] rank, input int p);
      logic [RW-1:0] re;
      logic [RW-1:0] k;
      logic [DIM_BITS-1:0] sz;
      re = (rank > RW'(MAX_DIMS)) ? RW'(MAX_DIMS) : rank;
      k = RW'(MAX_DIMS - 1 - p);
      sz = DIM_BITS'(1);
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (re > k && RW'(j) == re - k - RW'(1))
            sz = shape[j*DIM_BITS +: DIM_BITS];
      end
      return sz;
   endfunction

   logic [MAX_DIMS-1:0][DIM_BITS-1:0] asz, bsz, osz;
   logic bad;

   always_comb begin
      bad = 1'b0;
      for (int p = 0; p < MAX_DIMS; p++) begin
         asz[p] = aligned_size(shape_a_ff, rank_a_ff, p);
         bsz[p] = aligned_size(shape_b_ff, rank_b_ff, p);
         osz[p] = (asz[p] > bsz[p]) ? asz[p] : bsz[p];
         if (asz[p] == '0 || bsz[p] == '0)
            bad = 1'b1;
         if (asz[p] != bsz[p] && asz[p] != DIM_BITS'(1) && bsz[p] != DIM_BITS'(1))
            bad = 1'b1;
      end
   end

   // operand strides, one registered multiply per outer dimension; innermost stride is 1
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0] stride_a_ff, stride_b_ff;
   for (genvar p = 0; p < MAX_DIMS; p++) begin : g_stride
      if (p == MAX_DIMS - 1) begin : g_inner
         always_ff @(posedge clock) begin
            stride_a_ff[p] <= INDEX_BITS'(1);
            stride_b_ff[p] <= INDEX_BITS'(1);
         end
      end else begin : g_outer
         logic [INDEX_BITS+DIM_BITS-1:0] sa_in, sb_in;
         assign sa_in = stride_a_ff[p+1] * asz[p+1];
         assign sb_in = stride_b_ff[p+1] * bsz[p+1];
         always_ff @(posedge clock) begin
            stride_a_ff[p] <= sa_in[INDEX_BITS-1:0];
            stride_b_ff[p] <= sb_in[INDEX_BITS-1:0];
         end
      end
   end

   // pipeline advance: whole pipe holds while the result is stalled
   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // restoring divide, nb bits of quotient per call
   function automatic div_type div_step(input div_type d, input logic [DIM_BITS-1:0] dv,
                                        input int nb);
      div_type o;
      logic [DIM_BITS:0] t;
      o = d;
      for (int b = 0; b < K; b++) begin
         if (b < nb) begin
            t = {o.r, o.w[INDEX_BITS-1]};
            o.w = {o.w[INDEX_BITS-2:0], 1'b0};
            if (t >= {1'b0, dv}) begin
               t = t - {1'b0, dv};
               o.w[0] = 1'b1;
            end
            o.r = t[DIM_BITS-1:0];
         end
      end
      return o;
   endfunction

   div_type st_d [NS];
   div_type st_ff [NS];
   logic [NS-1:0] v_ff;

   assign st_d[0] = {INDEX_BITS'(req_out_linear_index), {(DIM_BITS * (MAX_DIMS + 1)){1'b0}}};

   for (genvar s = 0; s < NS; s++) begin : g_div
      localparam int P = MAX_DIMS - 1 - s / SPD;
      localparam int G = s % SPD;
      localparam int NB = (INDEX_BITS - G * K < K) ? INDEX_BITS - G * K : K;
      div_type st_in;
      always_comb begin
         st_in = div_step(st_d[s], osz[P], NB);
         if (G == SPD - 1) begin
            st_in.c[P] = st_in.r;
            st_in.r = '0;
         end
      end
      if (s > 0) begin : g_link
         assign st_d[s] = st_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= (s == 0) ? (req_valid && !req_stall) : v_ff[s-1 < 0 ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) st_ff[s] <= st_in;
      end
   end

   // products of coordinates and strides
   logic [MAX_DIMS-1:0][INDEX_BITS-1:0] pa_ff, pb_ff;
   logic pv_ff;
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (adv) pv_ff <= v_ff[NS-1];
   end
   for (genvar p = 0; p < MAX_DIMS; p++) begin : g_prod
      logic [DIM_BITS-1:0] ca, cb;
      logic [INDEX_BITS+DIM_BITS-1:0] pa_in, pb_in;
      assign ca = (asz[p] == DIM_BITS'(1)) ? '0 : st_ff[NS-1].c[p];
      assign cb = (bsz[p] == DIM_BITS'(1)) ? '0 : st_ff[NS-1].c[p];
      assign pa_in = stride_a_ff[p] * ca;
      assign pb_in = stride_b_ff[p] * cb;
      always_ff @(posedge clock) begin
         if (adv) begin
            pa_ff[p] <= pa_in[INDEX_BITS-1:0];
            pb_ff[p] <= pb_in[INDEX_BITS-1:0];
         end
      end
   end

   // sum and output register
   logic [INDEX_BITS-1:0] sa_in, sb_in;
   logic [tbim_pkg::LIN_W-1:0] ia_ff, ib_ff;
   logic bad_ff, ov_ff;
   always_comb begin
      sa_in = '0;
      sb_in = '0;
      for (int p = 0; p < MAX_DIMS; p++) begin
         sa_in = sa_in + pa_ff[p];
         sb_in = sb_in + pb_ff[p];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= pv_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ia_ff <= bad ? '0 : tbim_pkg::LIN_W'(sa_in);
         ib_ff <= bad ? '0 : tbim_pkg::LIN_W'(sb_in);
         bad_ff <= bad;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_index_a = ia_ff;
   assign rsp_index_b = ib_ff;
   assign rsp_shape_mismatch = bad_ff;

   `ASSERT_IMPLIES(a_mismatch_zero, clock, reset, rsp_valid && rsp_shape_mismatch,
                   rsp_index_a == '0 && rsp_index_b == '0)
   `ASSERT_ALWAYS(a_stall_link, clock, reset, req_stall == (rsp_valid && rsp_stall))
   `ASSERT_IMPLIES(a_pipe_frozen, clock, reset, rsp_valid && rsp_stall, ##1 $stable(v_ff))
endmodule
